[rtl/core/bvm_pkg.sv]
// Package for the battery voltage monitor: widths, register indexes,
// configuration and controller/datapath interface types.
// No dependencies.
package bvm_pkg;

    // Window and ADC sizing
    localparam int SAMPLES_PER_UPDATE = 16;
    localparam int ADC_BITS           = 12;
    localparam int CNT_W              = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
    localparam int SUM_W              = ADC_BITS + $clog2(SAMPLES_PER_UPDATE);

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int IN_TDATA_W  = 16;
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int OUT_TDATA_W = 24;

    // Fixed-point widths
    localparam int SCALE_W   = 24;
    localparam int ALPHA_W   = 9;
    localparam int Q_W       = 24;
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = ADC_BITS + SCALE_W;
    localparam int BP_W      = Q_W + ALPHA_W + 1;
    localparam int NUM_W     = MV_W + PCT_W;
    localparam int DIV_BIT_W = $clog2(PCT_W);

    localparam logic [Q_W-1:0]     Q_MAX     = {Q_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
    localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW   = CFG_INDEX_W'(4);

    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(52800);
    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(26);
    localparam logic [MV_W-1:0]    FULL_RST  = MV_W'(4150);
    localparam logic [MV_W-1:0]    EMPTY_RST = MV_W'(3200);
    localparam logic [MV_W-1:0]    LOW_RST   = MV_W'(3700);

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [ALPHA_W-1:0] alpha;
        logic [MV_W-1:0]    full;
        logic [MV_W-1:0]    empty;
        logic [MV_W-1:0]    low;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic                 acc;
        logic                 mul;
        logic                 blend;
        logic                 pct;
        logic                 div_step;
        logic [DIV_BIT_W-1:0] div_bit;
        logic                 load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic win_last;
        logic pct_clamped;
    } sts_t;

endpackage

[rtl/core/bvm_cfg.sv]
// Configuration register file of the battery voltage monitor.
// Depends on bvm_pkg.
module bvm_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bvm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bvm_pkg::cfg_t                    cfg
);

    bvm_pkg::cfg_t cfg_reg;
    bvm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bvm_pkg::CFG_SCALE: cfg_next.scale = cfg_data[bvm_pkg::SCALE_W-1:0];
                bvm_pkg::CFG_ALPHA: cfg_next.alpha = cfg_data[bvm_pkg::ALPHA_W-1:0];
                bvm_pkg::CFG_FULL:  cfg_next.full  = cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_EMPTY: cfg_next.empty = cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_LOW:   cfg_next.low   = cfg_data[bvm_pkg::MV_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale <= bvm_pkg::SCALE_RST;
            cfg_reg.alpha <= bvm_pkg::ALPHA_RST;
            cfg_reg.full  <= bvm_pkg::FULL_RST;
            cfg_reg.empty <= bvm_pkg::EMPTY_RST;
            cfg_reg.low   <= bvm_pkg::LOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/bvm_dp.sv]
// Datapath of the battery voltage monitor: window accumulator, scaling
// multiply, EMA blend, percentage divider and output payload register.
// Depends on bvm_pkg.
module bvm_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bvm_pkg::cfg_t                     cfg,
    input  bvm_pkg::cmd_t                     cmd,
    input  logic [bvm_pkg::SAMPLE_W-1:0]      sample,
    output bvm_pkg::sts_t                     sts,
    output logic [bvm_pkg::MV_W-1:0]          battery_mv,
    output logic [bvm_pkg::PCT_W-1:0]         percent,
    output logic                              low_flag
);

    // Window state
    logic [bvm_pkg::SUM_W-1:0]    sum_reg,   sum_next;
    logic [bvm_pkg::CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [bvm_pkg::ADC_BITS-1:0] avg_reg,   avg_next;
    logic [bvm_pkg::Q_W-1:0]      fresh_reg, fresh_next;
    logic [bvm_pkg::Q_W-1:0]      ema_reg,   ema_next;
    logic                         seeded_reg, seeded_next;

    // Divider state
    logic [bvm_pkg::NUM_W-1:0]    rem_reg,   rem_next;
    logic [bvm_pkg::MV_W-1:0]     den_reg,   den_next;
    logic [bvm_pkg::PCT_W-1:0]    quo_reg,   quo_next;

    // Output payload
    logic [bvm_pkg::MV_W-1:0]     mv_out_reg,  mv_out_next;
    logic [bvm_pkg::PCT_W-1:0]    pct_out_reg, pct_out_next;
    logic                         low_out_reg, low_out_next;

    logic [bvm_pkg::SUM_W-1:0]       total;
    logic [bvm_pkg::PROD_W-1:0]      prod;
    logic [bvm_pkg::PROD_W-1:0]      prod_sh;
    logic [bvm_pkg::ALPHA_W-1:0]     alpha_c;
    logic signed [bvm_pkg::Q_W:0]    diff;
    logic signed [bvm_pkg::BP_W-1:0] bprod;
    logic signed [bvm_pkg::BP_W-1:0] bsum;
    logic [bvm_pkg::MV_W-1:0]        mv;
    logic                            at_full;
    logic                            at_empty;
    logic [bvm_pkg::NUM_W-1:0]       trial;

    assign sts.win_last = (cnt_reg == bvm_pkg::CNT_W'(bvm_pkg::SAMPLES_PER_UPDATE - 1));

    assign total   = sum_reg + bvm_pkg::SUM_W'(sample[bvm_pkg::ADC_BITS-1:0]);
    assign prod    = bvm_pkg::PROD_W'(avg_reg) * bvm_pkg::PROD_W'(cfg.scale);
    assign prod_sh = prod >> bvm_pkg::FRAC_BITS;

    // ema + a*(fresh-ema)/256 with floor shift equals the weighted sum form
    assign alpha_c = (cfg.alpha > bvm_pkg::ALPHA_ONE) ? bvm_pkg::ALPHA_ONE : cfg.alpha;
    assign diff    = $signed({1'b0, fresh_reg}) - $signed({1'b0, ema_reg});
    assign bprod   = diff * $signed({1'b0, alpha_c});
    assign bsum    = $signed(bvm_pkg::BP_W'(ema_reg)) + (bprod >>> bvm_pkg::FRAC_BITS);

    assign mv       = ema_reg[bvm_pkg::Q_W-1 -: bvm_pkg::MV_W];
    assign at_full  = (mv >= cfg.full);
    assign at_empty = (mv <= cfg.empty);
    assign sts.pct_clamped = at_full || at_empty;

    assign trial = bvm_pkg::NUM_W'(den_reg) << cmd.div_bit;

    always_comb
    begin
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        avg_next     = avg_reg;
        fresh_next   = fresh_reg;
        ema_next     = ema_reg;
        seeded_next  = seeded_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        mv_out_next  = mv_out_reg;
        pct_out_next = pct_out_reg;
        low_out_next = low_out_reg;

        if (cmd.acc)
        begin
            if (sts.win_last)
            begin
                avg_next = bvm_pkg::ADC_BITS'(total / bvm_pkg::SAMPLES_PER_UPDATE);
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = total;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (cmd.mul)
        begin
            if (prod_sh > bvm_pkg::PROD_W'(bvm_pkg::Q_MAX))
                fresh_next = bvm_pkg::Q_MAX;
            else
                fresh_next = prod_sh[bvm_pkg::Q_W-1:0];
        end

        if (cmd.blend)
        begin
            seeded_next = 1'b1;
            if (seeded_reg)
                ema_next = bsum[bvm_pkg::Q_W-1:0];
            else
                ema_next = fresh_reg;
        end

        if (cmd.pct)
        begin
            rem_next = bvm_pkg::NUM_W'(mv - cfg.empty) * bvm_pkg::NUM_W'(bvm_pkg::PCT_FULL);
            den_next = cfg.full - cfg.empty;
            if (at_full)
                quo_next = bvm_pkg::PCT_FULL;
            else
                quo_next = '0;
        end

        if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                quo_next[cmd.div_bit] = 1'b1;
            end
        end

        if (cmd.load_out)
        begin
            mv_out_next  = mv;
            pct_out_next = quo_reg;
            low_out_next = (mv != '0) && (mv < cfg.low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cnt_reg    <= '0;
            ema_reg    <= '0;
            seeded_reg <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            ema_reg    <= ema_next;
            seeded_reg <= seeded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        fresh_reg   <= fresh_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        mv_out_reg  <= mv_out_next;
        pct_out_reg <= pct_out_next;
        low_out_reg <= low_out_next;
    end

    assign battery_mv = mv_out_reg;
    assign percent    = pct_out_reg;
    assign low_flag   = low_out_reg;

endmodule

[rtl/core/bvm_ctrl.sv]
// Controller of the battery voltage monitor: sequences accumulate,
// scale, blend, percentage division and output handoff.
// Depends on bvm_pkg.
module bvm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  bvm_pkg::sts_t sts,
    output bvm_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_BLEND = 3'd2;
    localparam logic [2:0] ST_PCT   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [bvm_pkg::DIV_BIT_W-1:0] DIV_TOP = bvm_pkg::DIV_BIT_W'(bvm_pkg::PCT_W - 1);

    logic [2:0]                      state_reg, state_next;
    logic [bvm_pkg::DIV_BIT_W-1:0]   bit_reg,   bit_next;
    logic                            valid_reg, valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        bit_next     = bit_reg;
        valid_next   = valid_reg;
        cmd          = '0;
        cmd.div_bit  = bit_reg;

        // drop the result once taken
        if (valid_reg && m_tready)
            valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.acc = 1'b1;
                    if (sts.win_last)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = ST_PCT;
            end
            ST_PCT:
            begin
                cmd.pct  = 1'b1;
                bit_next = DIV_TOP;
                if (sts.pct_clamped)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_OUT;
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/core/battery_voltage_monitor_ema.sv]
// Flow: the last sample of a window is registered, then MUL, BLEND, PCT, the
//   7-step divider (skipped when the percentage clamps) and OUT run before m_tvalid rises.
// Throughput: one sample per cycle within a window; the window-closing sample
//   holds s_tready low until its result is loaded, longer while the prior result waits.
// Reset (rst_n low, async): window and EMA cleared, filter unseeded,
//   registers back to their defaults, no result pending.
module battery_voltage_monitor_ema
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bvm_pkg::IN_TDATA_W-1:0]      s_tdata,   // [11:0] sample, rest zero
    // Gauge result out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bvm_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [15:0] battery_mv,
                                                           // [22:16] percent, [23] low_flag
    // Register writes
    input  logic                                cfg_we,
    input  logic [bvm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    bvm_pkg::cfg_t cfg;
    bvm_pkg::cmd_t cmd;
    bvm_pkg::sts_t sts;

    logic [bvm_pkg::MV_W-1:0]  battery_mv;
    logic [bvm_pkg::PCT_W-1:0] percent;
    logic                      low_flag;

    // Registers: scale, alpha, full, empty, low thresholds
    bvm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: accepts samples only while idle, owns the result valid
    bvm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic: accumulate, scale to Q16.8 mV, blend, divide for percent
    bvm_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sample     (s_tdata[bvm_pkg::SAMPLE_W-1:0]),
        .sts        (sts),
        .battery_mv (battery_mv),
        .percent    (percent),
        .low_flag   (low_flag)
    );

    // Pack the result fields: low_flag on top, battery_mv in the lowest bits
    assign m_tdata = {low_flag, percent, battery_mv};

endmodule

[rtl/core/bvm_checker.sv]
// Port-level checker for the battery voltage monitor, bound to the top level.
// Depends on bvm_pkg and battery_voltage_monitor_ema.
module bvm_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bvm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // Percentage never exceeds full charge
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[22:16] <= bvm_pkg::PCT_FULL)
        else $error("percent above full charge");

    // Low flag only with a nonzero voltage
    a_low_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[23] |-> m_tdata[15:0] != '0)
        else $error("low flag raised at zero millivolts");

endmodule

bind battery_voltage_monitor_ema bvm_checker u_bvm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb_battery_voltage_monitor_ema.sv]
// Self-checking bench for battery_voltage_monitor_ema: sample stream in, gauge readings out.
// Predicts each window's reading in a tracker class and compares every field.
// Depends on bvm_pkg and the battery_voltage_monitor_ema RTL only.
`timescale 1ns / 100ps

module tb_battery_voltage_monitor_ema;

    import bvm_pkg::*;

    localparam int ITEM_TARGET     = 1450;
    localparam int DRAIN_CYCLES    = 20;    // longer than the worst-case result latency
    localparam int HOLD_CYCLES     = 300;   // long receiver back-off
    localparam int WATCHDOG_LIMIT  = 2000;

    // One gauge reading, laid out exactly as m_tdata: low flag on top, millivolts at the bottom
    typedef struct packed {
        logic             low;
        logic [PCT_W-1:0] pct;
        logic [MV_W-1:0]  mv;
    } gauge_reading_t;

    // Tracks the gauge: window accumulation, EMA state, registers, and the readings due
    class gauge_checker;
        cfg_t                 regs;
        logic [SUM_W-1:0]     win_sum;
        int                   win_cnt;
        logic [Q_W-1:0]       ema_q8;
        bit                   seeded;
        gauge_reading_t       readings_due[$];
        int                   errors;

        function new();
            regs    = '{scale: SCALE_RST, alpha: ALPHA_RST, full: FULL_RST,
                        empty: EMPTY_RST, low: LOW_RST};
            win_sum = '0;
            win_cnt = 0;
            ema_q8  = '0;
            seeded  = 0;
            errors  = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SCALE: regs.scale = value[SCALE_W-1:0];
                CFG_ALPHA: regs.alpha = value[ALPHA_W-1:0];
                CFG_FULL:  regs.full  = value[MV_W-1:0];
                CFG_EMPTY: regs.empty = value[MV_W-1:0];
                CFG_LOW:   regs.low   = value[MV_W-1:0];
                default: ;
            endcase
        endfunction

        // Take one accepted sample; queue a reading when it closes a window
        function void absorb_sample(logic [SAMPLE_W-1:0] s);
            logic [SUM_W-1:0] avg;
            logic [63:0]      prod;
            logic [63:0]      mix;
            logic [Q_W-1:0]   fresh;
            logic [31:0]      weight;
            logic [31:0]      span;
            gauge_reading_t   r;
            win_sum += SUM_W'(s);
            win_cnt++;
            if (win_cnt < SAMPLES_PER_UPDATE)
                return;
            avg     = win_sum / SUM_W'(SAMPLES_PER_UPDATE);
            win_sum = '0;
            win_cnt = 0;
            // scale to Q16.8 millivolts, saturate
            prod = (64'(avg) * 64'(regs.scale)) >> FRAC_BITS;
            fresh = (prod > 64'(Q_MAX)) ? Q_MAX : prod[Q_W-1:0];
            if (seeded)
            begin
                weight = (regs.alpha > 9'd256) ? 32'd256 : 32'(regs.alpha);
                mix    = (64'(weight) * 64'(fresh) + 64'(256 - weight) * 64'(ema_q8)) >> 8;
                ema_q8 = mix[Q_W-1:0];
            end
            else
            begin
                ema_q8 = fresh;
                seeded = 1;
            end
            r.mv = ema_q8[Q_W-1:FRAC_BITS];
            if (r.mv >= regs.full)
                r.pct = PCT_FULL;
            else if (r.mv <= regs.empty)
                r.pct = '0;
            else
            begin
                span  = 32'(regs.full) - 32'(regs.empty);
                r.pct = PCT_W'(((32'(r.mv) - 32'(regs.empty)) * 32'd100) / span);
            end
            r.low = (r.mv != '0) && (r.mv < regs.low);
            readings_due.push_back(r);
        endfunction

        function void check_reading(logic [OUT_TDATA_W-1:0] word);
            gauge_reading_t got;
            gauge_reading_t want;
            got = word;
            if (readings_due.size() == 0)
            begin
                $error("unexpected reading: battery_mv %0d, percent %0d, low_flag %0d",
                       got.mv, got.pct, got.low);
                errors++;
                return;
            end
            want = readings_due.pop_front();
            if (got.mv !== want.mv)
            begin
                $error("battery_mv: expected %0d, actual %0d", want.mv, got.mv);
                errors++;
            end
            if (got.pct !== want.pct)
            begin
                $error("percent: expected %0d, actual %0d", want.pct, got.pct);
                errors++;
            end
            if (got.low !== want.low)
            begin
                $error("low_flag: expected %0d, actual %0d", want.low, got.low);
                errors++;
            end
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [11:0] sample, rest zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [15:0] battery_mv, [22:16] percent, [23] low_flag
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gauge_checker gauge = new();

    // Flow control knobs shared by the sender and the receiver
    bit steady_flow;     // no idle cycles on either side
    bit hold_results;    // receiver backs off for HOLD_CYCLES once
    int sent;

    // Directed window: field extremes and alternating bit patterns
    localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [16] = '{
        12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'hFFE, 12'h7FF,
        12'h000, 12'hFFF, 12'hF0F, 12'h0F0, 12'h123, 12'hEDC, 12'h400, 12'hBFF
    };

    // Register settings covering the corner behaviors
    localparam cfg_t CORNER_CFGS [6] = '{
        // largest scale saturates the Q16.8 value, alpha 256 takes the new value whole
        '{scale: 24'hFFFFFF, alpha: 9'd256, full: 16'hFFFF, empty: 16'h0000, low: 16'hFFFF},
        // zero scale gives a zero fresh value; every threshold at zero
        '{scale: 24'h000000, alpha: 9'd1,   full: 16'h0000, empty: 16'h0000, low: 16'h0000},
        // alpha zero freezes the filter
        '{scale: 24'd52800,  alpha: 9'd0,   full: 16'd4150, empty: 16'd3200, low: 16'd3700},
        // alpha beyond 256 clamps; full below empty
        '{scale: 24'd98304,  alpha: 9'h1FF, full: 16'd1000, empty: 16'd3000, low: 16'd2000},
        // full equal to empty
        '{scale: 24'd65536,  alpha: 9'd300, full: 16'd2000, empty: 16'd2000, low: 16'd2500},
        // one millivolt per count, mid alpha, full linear range
        '{scale: 24'd65536,  alpha: 9'd128, full: 16'd4095, empty: 16'd0,    low: 16'd2048}
    };

    battery_voltage_monitor_ema dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Write one register: drive at the falling edge, note it once the rising edge takes it.
    // cfg_we stays high across back-to-back writes and is dropped by write_config.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        gauge.set_register(idx, value);
    endtask

    // Load every register; only call while the block is idle
    task automatic write_config(input cfg_t c);
        write_reg(CFG_SCALE, CFG_DATA_W'(c.scale));
        write_reg(CFG_ALPHA, CFG_DATA_W'(c.alpha));
        write_reg(CFG_FULL,  CFG_DATA_W'(c.full));
        write_reg(CFG_EMPTY, CFG_DATA_W'(c.empty));
        write_reg(CFG_LOW,   CFG_DATA_W'(c.low));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one sample request and hold it until accepted. Entered right after a rising
    // edge; tvalid is only lowered when an idle gap is drawn, so a back-to-back request
    // never sees two assignments in one step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gauge.absorb_sample(value);
        sent++;
    endtask

    // Stream samples around a level that moves every window; now and then a window of
    // full-range noise so every bit toggles and the average swings hard
    task automatic run_samples(input int count);
        int level;
        int spread;
        int v;
        for (int i = 0; i < count; i++)
        begin
            if (i % SAMPLES_PER_UPDATE == 0)
            begin
                level  = $urandom_range(0, 4095);
                spread = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 64);
            end
            v = level - spread + int'($urandom_range(0, 2 * spread));
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            send_sample(SAMPLE_W'(v));
        end
    endtask

    // Drop valid, drain every expected reading, then wait out a window still being closed
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (gauge.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random setting; thresholds are placed inside the reachable millivolt range
    function automatic cfg_t random_config();
        cfg_t        c;
        longint      top;
        logic [15:0] t;
        c.scale = ($urandom_range(0, 9) == 0) ? SCALE_W'($urandom)
                                              : SCALE_W'($urandom_range(16384, 262144));
        c.alpha = ($urandom_range(0, 9) == 0) ? ALPHA_W'($urandom)
                                              : ALPHA_W'($urandom_range(1, 256));
        top = (longint'(4095) * longint'(c.scale)) >> 16;
        if (top > 65535)
            top = 65535;
        c.empty = MV_W'($urandom_range(0, int'(top)));
        c.full  = MV_W'($urandom_range(int'(c.empty), int'(top)));
        c.low   = MV_W'($urandom_range(0, int'(top)));
        if ($urandom_range(0, 9) == 0)
        begin
            // swap to get full below empty
            t       = c.full;
            c.full  = c.empty;
            c.empty = t;
        end
        return c;
    endfunction

    // Receiver: draw a wait per reading, back off once for a long stretch on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 0;
            end
            gap = steady_flow ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Monitor: check every accepted reading against the oldest one due
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                gauge.check_reading(m_tdata);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int phase;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady_flow  = 0;
        hold_results = 0;
        sent         = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed window at the reset defaults; this one seeds the filter
        foreach (CORNER_SAMPLES[k])
            send_sample(CORNER_SAMPLES[k]);
        settle();

        // Corner settings; end most phases mid-window so a window straddles the change
        foreach (CORNER_CFGS[k])
        begin
            write_config(CORNER_CFGS[k]);
            run_samples($urandom_range(3, 5) * SAMPLES_PER_UPDATE
                        + $urandom_range(0, SAMPLES_PER_UPDATE - 1));
            settle();
        end

        // Random settings; phase 1 stalls the receiver so the block backs up into its
        // input, every fourth phase runs with no idle cycles at all
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            write_config(random_config());
            steady_flow  = (phase % 4 == 3) || (phase == 1);
            hold_results = (phase == 1);
            run_samples($urandom_range(2, 8) * SAMPLES_PER_UPDATE
                        + $urandom_range(0, SAMPLES_PER_UPDATE - 1));
            steady_flow = 0;
            settle();
            phase++;
        end

        if (gauge.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/core/bvm_pkg.sv
rtl/core/bvm_cfg.sv
rtl/core/bvm_dp.sv
rtl/core/bvm_ctrl.sv
rtl/core/battery_voltage_monitor_ema.sv
rtl/core/bvm_checker.sv
bench/tb_battery_voltage_monitor_ema.sv
